// ----- rtl/fbfl_pkg.sv -----
// shared types, constants and helpers of the free-list allocator
`default_nettype none

package fbfl_pkg;

  localparam int unsigned NumBlocks = 256;
  localparam int unsigned IdxW      = $clog2(NumBlocks);
  localparam int unsigned LinkW     = IdxW + 1;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [LinkW-1:0] link_t;

  localparam link_t LinkNull = link_t'(NumBlocks);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_ORD   = 2'd2
  } kind_e;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  // link held by an entry that was never written
  function automatic link_t link_reset(idx_t a);
    link_t r;
    if (a == idx_t'(NumBlocks - 1)) begin
      r = LinkNull;
    end else begin
      r = link_t'(a) + link_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fbfl_link_mem.sv -----
// next-link memory with per-entry written bits and registered read
`default_nettype none

module fbfl_link_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fbfl_pkg::link_wr_t wr_i,
  input  wire fbfl_pkg::idx_t    rd_addr_i,
  output      fbfl_pkg::link_t   rd_data_o
);

  fbfl_pkg::link_t mem [fbfl_pkg::NumBlocks];
  logic [fbfl_pkg::NumBlocks-1:0] written_q;
  fbfl_pkg::link_t rd_q;
  logic            rd_written_q;
  fbfl_pkg::idx_t  rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_i.we) begin
      written_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q         <= mem[rd_addr_i];
    rd_written_q <= written_q[rd_addr_i];
    rd_addr_q    <= rd_addr_i;
  end

  assign rd_data_o = rd_written_q ? rd_q : fbfl_pkg::link_reset(rd_addr_q);

endmodule

`default_nettype wire

// ----- rtl/fbfl_ctrl.sv -----
// request sequencer: head, free bits, shared index compare, result register
`default_nettype none

module fbfl_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire fbfl_pkg::idx_t     block_index_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      fbfl_pkg::idx_t     granted_index_o,
  output      logic               granted_o,
  output      logic               now_empty_o,
  output      fbfl_pkg::link_wr_t link_wr_o,
  output      fbfl_pkg::idx_t     link_rd_addr_o,
  input  wire fbfl_pkg::link_t    link_rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_PUSH,
    S_ORD,
    S_WALK,
    S_LINK,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  fbfl_pkg::idx_t  idx_q, idx_d;
  fbfl_pkg::link_t head_q, head_d;
  fbfl_pkg::link_t cur_q, cur_d;
  logic [fbfl_pkg::NumBlocks-1:0] free_q, free_d;
  logic            free_hit_q, free_hit_d;
  logic            res_grant_q, res_grant_d;
  fbfl_pkg::idx_t  res_idx_q, res_idx_d;
  logic            out_valid_q, out_valid_d;
  fbfl_pkg::idx_t  out_idx_q, out_idx_d;
  logic            out_grant_q, out_grant_d;
  logic            out_empty_q, out_empty_d;

  fbfl_pkg::link_t cmp_b;
  logic            idx_lt;
  logic            head_null;

  // shared compare unit
  assign cmp_b     = (state_q == S_WALK) ? link_rd_data_i : head_q;
  assign idx_lt    = {1'b0, idx_q} < cmp_b;
  assign head_null = (head_q == fbfl_pkg::LinkNull);

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    head_d         = head_q;
    cur_d          = cur_q;
    free_d         = free_q;
    free_hit_d     = free_hit_q;
    res_grant_d    = res_grant_q;
    res_idx_d      = res_idx_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_idx_d      = out_idx_q;
    out_grant_d    = out_grant_q;
    out_empty_d    = out_empty_q;
    link_wr_o      = '0;
    link_rd_addr_o = head_q[fbfl_pkg::IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d       = block_index_i;
          free_hit_d  = free_q[block_index_i];
          res_grant_d = 1'b0;
          res_idx_d   = '0;
          case (kind_i)
            fbfl_pkg::KIND_ALLOC: state_d = S_ALLOC;
            fbfl_pkg::KIND_PUSH:  state_d = S_PUSH;
            fbfl_pkg::KIND_ORD:   state_d = S_ORD;
            default:              state_d = S_RESP;
          endcase
        end
      end
      S_ALLOC: begin
        if (!head_null) begin
          res_grant_d = 1'b1;
          res_idx_d   = head_q[fbfl_pkg::IdxW-1:0];
          free_d[head_q[fbfl_pkg::IdxW-1:0]] = 1'b0;
          head_d      = link_rd_data_i;
        end
        state_d = S_RESP;
      end
      S_PUSH: begin
        if (!free_hit_q) begin
          link_wr_o.we   = 1'b1;
          link_wr_o.addr = idx_q;
          link_wr_o.data = head_q;
          head_d         = {1'b0, idx_q};
          free_d[idx_q]  = 1'b1;
        end
        state_d = S_RESP;
      end
      S_ORD: begin
        if (free_hit_q) begin
          state_d = S_RESP;
        end else if (idx_lt) begin
          state_d = S_PUSH;
        end else begin
          cur_d   = head_q;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (idx_lt) begin
          link_wr_o.we   = 1'b1;
          link_wr_o.addr = idx_q;
          link_wr_o.data = link_rd_data_i;
          state_d        = S_LINK;
        end else begin
          cur_d          = link_rd_data_i;
          link_rd_addr_o = link_rd_data_i[fbfl_pkg::IdxW-1:0];
        end
      end
      S_LINK: begin
        link_wr_o.we   = 1'b1;
        link_wr_o.addr = cur_q[fbfl_pkg::IdxW-1:0];
        link_wr_o.data = {1'b0, idx_q};
        free_d[idx_q]  = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_grant_d = res_grant_q;
          out_empty_d = head_null;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      free_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cur_q       <= cur_d;
    free_hit_q  <= free_hit_d;
    res_grant_q <= res_grant_d;
    res_idx_q   <= res_idx_d;
    out_idx_q   <= out_idx_d;
    out_grant_q <= out_grant_d;
    out_empty_q <= out_empty_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign granted_index_o = out_idx_q;
  assign granted_o       = out_grant_q;
  assign now_empty_o     = out_empty_q;

endmodule

`default_nettype wire

// ----- rtl/fixed_block_free_list_allocator_unit.sv -----
// top level of the fixed-block free-list allocator
//
//   channel  direction  fields
//   in       sink       kind_i, block_index_i
//   out      source     granted_index_o, granted_o, now_empty_o
//
// allocate and release at head: S_ALLOC or S_PUSH, then S_RESP registers the result
// ordered release: S_ORD, then S_PUSH at the head or S_WALK per link walked and S_LINK
// ordered release of a block already free: S_ORD, then S_RESP; unused kind: S_RESP alone
// one transaction in flight; in_ready_o is low from acceptance until the result is queued
// a result stalled at the output holds the sequencer only in its last step
// no clearing pass after reset: unwritten link entries read their reset value
`default_nettype none

module fixed_block_free_list_allocator_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] block_index_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] granted_index_o,
  output      logic       granted_o,
  output      logic       now_empty_o
);

  fbfl_pkg::link_wr_t link_wr;
  fbfl_pkg::idx_t     link_rd_addr;
  fbfl_pkg::link_t    link_rd_data;

  fbfl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .block_index_i  (block_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_index_o(granted_index_o),
    .granted_o      (granted_o),
    .now_empty_o    (now_empty_o),
    .link_wr_o      (link_wr),
    .link_rd_addr_o (link_rd_addr),
    .link_rd_data_i (link_rd_data)
  );

  fbfl_link_mem u_link_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (link_wr),
    .rd_addr_i(link_rd_addr),
    .rd_data_o(link_rd_data)
  );

endmodule

`default_nettype wire

// ----- rtl/fbfl_checker.sv -----
// port-level checks of the allocator, bound to the top level
`default_nettype none

module fbfl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] granted_index_o,
  input wire logic       granted_o,
  input wire logic       now_empty_o
);

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction is in progress");

  // no grant means index zero
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> granted_index_o == 8'd0)
    else $error("nonzero index without a grant");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_index_o)
      && $stable(granted_o) && $stable(now_empty_o))
    else $error("stalled result changed");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker u_fbfl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .granted_index_o(granted_index_o),
  .granted_o      (granted_o),
  .now_empty_o    (now_empty_o)
);

`default_nettype wire
